// File: hdl/go_back_n_sender_window_defines.svh
// Assertion macros for the go-back-n sender window.
// Used by the top level only; needs signals clk and arst_n in scope.
`ifndef GO_BACK_N_SENDER_WINDOW_DEFINES_SVH
`define GO_BACK_N_SENDER_WINDOW_DEFINES_SVH

// Checked on every rising edge outside reset.
`define GBN_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define GBN_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/gbn_pkg.sv
// Shared types and constants for the go-back-n sender window.
// No dependencies; imported by every module of the block except the frame RAM.
package gbn_pkg;

	localparam int SEQ_BITS     = 3;
	localparam int PAYLOAD_BITS = 32;
	localparam int USER_W       = 2;
	localparam int IN_DATA_W    = ((PAYLOAD_BITS + SEQ_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W   = ((PAYLOAD_BITS + 3 * SEQ_BITS + 7) / 8) * 8;

	typedef logic [SEQ_BITS-1:0]     seq_t;
	typedef logic [PAYLOAD_BITS-1:0] payload_t;

	// Largest number of unacked frames
	localparam seq_t WINDOW = '1;

	typedef enum logic [1:0] {
		ACT_SEND    = 2'd0,
		ACT_ACK     = 2'd1,
		ACT_NAK     = 2'd2,
		ACT_TIMEOUT = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		KIND_FRAME   = 2'd0,
		KIND_REFUSED = 2'd1,
		KIND_ACK     = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EMIT = 1'b1
	} state_t;

	// One result beat
	typedef struct packed {
		kind_t    kind;
		seq_t     seq;
		payload_t frame_data;
		seq_t     freed;
		seq_t     outstanding;
		logic     last;
	} result_t;

	// Window status seen by the top level
	typedef struct packed {
		seq_t next_seq;
		seq_t oldest;
		seq_t in_flight;
		logic busy;
	} status_t;

endpackage

// File: hdl/gbn_frame_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Holds the payloads of outstanding frames; no dependencies.
module gbn_frame_ram #(
	parameter int ADDR_BITS = 3,
	parameter int DATA_BITS = 32
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [ADDR_BITS-1:0] wr_addr,
	input  logic [DATA_BITS-1:0] wr_data,
	input  logic                 rd_en,
	input  logic [ADDR_BITS-1:0] rd_addr,
	output logic [DATA_BITS-1:0] rd_data
);

	logic [DATA_BITS-1:0] mem [(1 << ADDR_BITS)];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port, data held until next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hdl/gbn_seq_ctrl.sv
// Window sequencer: send, cumulative ack and go-back-n retransmit.
// Depends on gbn_pkg; drives the frame RAM and the output stage.
module gbn_seq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  gbn_pkg::action_t   in_action,
	input  gbn_pkg::payload_t  in_payload,
	input  gbn_pkg::seq_t      in_ack,
	input  logic               out_free,
	output gbn_pkg::result_t   res,
	output logic               res_load,
	output logic               ram_wr_en,
	output gbn_pkg::seq_t      ram_wr_addr,
	output gbn_pkg::payload_t  ram_wr_data,
	output logic               ram_rd_en,
	output gbn_pkg::seq_t      ram_rd_addr,
	input  gbn_pkg::payload_t  ram_rd_data,
	output gbn_pkg::status_t   status
);
	import gbn_pkg::*;

	state_t state_q;
	state_t state_d;
	seq_t   next_seq_q;
	seq_t   oldest_q;
	seq_t   in_flight_q;
	seq_t   rtx_ptr_q;
	seq_t   rtx_left_q;

	logic accept;
	logic is_rtx;
	logic full;
	seq_t ack_diff;
	logic ack_hit;
	seq_t ack_freed;
	logic rtx_start;
	logic rtx_step;
	logic rtx_done;

	// Handshake and window decode
	assign in_ready  = (state_q == ST_IDLE) && out_free;
	assign accept    = in_valid && in_ready;
	assign is_rtx    = (in_action == ACT_NAK) || (in_action == ACT_TIMEOUT);
	assign full      = (in_flight_q == WINDOW);
	assign ack_diff  = in_ack - oldest_q;
	assign ack_hit   = (ack_diff < in_flight_q);
	assign ack_freed = ack_diff + seq_t'(1);
	assign rtx_start = accept && is_rtx && (in_flight_q != '0);
	assign rtx_step  = (state_q == ST_EMIT) && out_free;
	assign rtx_done  = (rtx_left_q == seq_t'(1));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (rtx_start) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free && rtx_done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Result beat and RAM control
	always_comb begin
		res             = '0;
		res.kind        = KIND_FRAME;
		res_load        = 1'b0;
		ram_wr_en       = 1'b0;
		ram_wr_addr     = next_seq_q;
		ram_wr_data     = in_payload;
		ram_rd_en       = 1'b0;
		ram_rd_addr     = oldest_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res.last = 1'b1;
					case (in_action)
						ACT_SEND: begin
							res_load = 1'b1;
							res.seq  = next_seq_q;
							if (full) begin
								res.kind        = KIND_REFUSED;
								res.outstanding = in_flight_q;
							end else begin
								ram_wr_en       = 1'b1;
								res.kind        = KIND_FRAME;
								res.frame_data  = in_payload;
								res.outstanding = in_flight_q + seq_t'(1);
							end
						end
						ACT_ACK: begin
							res_load = 1'b1;
							res.kind = KIND_ACK;
							if (ack_hit) begin
								res.freed       = ack_freed;
								res.outstanding = in_flight_q - ack_freed;
							end else begin
								res.outstanding = in_flight_q;
							end
						end
						default: begin
							// nak or timeout: fetch oldest frame, or report idle window
							if (in_flight_q == '0) begin
								res_load = 1'b1;
								res.kind = KIND_NONE;
							end else begin
								ram_rd_en = 1'b1;
							end
						end
					endcase
				end
			end
			ST_EMIT: begin
				if (rtx_step) begin
					res_load        = 1'b1;
					res.kind        = KIND_FRAME;
					res.seq         = rtx_ptr_q;
					res.frame_data  = ram_rd_data;
					res.outstanding = in_flight_q;
					res.last        = rtx_done;
					// prefetch the following frame
					ram_rd_en       = !rtx_done;
					ram_rd_addr     = rtx_ptr_q + seq_t'(1);
				end
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Window pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_seq_q  <= '0;
			oldest_q    <= '0;
			in_flight_q <= '0;
		end else if (accept) begin
			if (in_action == ACT_SEND && !full) begin
				next_seq_q  <= next_seq_q + seq_t'(1);
				in_flight_q <= in_flight_q + seq_t'(1);
			end else if (in_action == ACT_ACK && ack_hit) begin
				oldest_q    <= in_ack + seq_t'(1);
				in_flight_q <= in_flight_q - ack_freed;
			end
		end
	end

	// Retransmit walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rtx_ptr_q  <= '0;
			rtx_left_q <= '0;
		end else if (rtx_start) begin
			rtx_ptr_q  <= oldest_q;
			rtx_left_q <= in_flight_q;
		end else if (rtx_step) begin
			rtx_ptr_q  <= rtx_ptr_q + seq_t'(1);
			rtx_left_q <= rtx_left_q - seq_t'(1);
		end
	end

	assign status.next_seq  = next_seq_q;
	assign status.oldest    = oldest_q;
	assign status.in_flight = in_flight_q;
	assign status.busy      = (state_q == ST_EMIT);

endmodule

// File: hdl/gbn_out_stage.sv
// Output register for result beats; lets the sequencer load while a beat drains.
// Depends on gbn_pkg.
module gbn_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  gbn_pkg::result_t din,
	output logic             free,
	output logic             out_valid,
	input  logic             out_ready,
	output gbn_pkg::result_t dout
);
	import gbn_pkg::*;

	logic    valid_q;
	result_t beat_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign dout      = beat_q;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (load) begin
			beat_q <= din;
		end
	end

endmodule

// File: hdl/go_back_n_sender_window.sv
// Go-back-n ARQ sender window, top level.
// Channels: s_axis carries requests (tuser = action: send, ack, nak, timeout;
// tdata = payload and ack number). m_axis carries results (tuser = kind,
// tlast = final beat of a request, tdata = seq, frame data, freed, outstanding).
// A send stores its payload in the frame RAM and returns one frame beat, or a
// refusal when seven frames are outstanding. An ack returns one beat with the
// count of frames it released. A nak or timeout returns a none beat when nothing
// is outstanding, else replays every outstanding frame oldest first, tlast on
// the last one. A send, ack or none result is registered in the output stage and
// appears in the cycle after its request is taken; a retransmit first reads the
// oldest frame into the RAM read register. Throughput: one request every cycle
// for send and ack, and one replayed beat per cycle, while the output stage is
// free; a retransmit holds s_axis_tready low until its last beat is loaded,
// paced by the single RAM read port. Reset clears the sequence numbers and the
// window count; the frame RAM is not cleared and needs no sweep, so requests are
// taken right after reset. When the receiver stalls, the output register holds
// its beat and s_axis_tready drops until it is taken. Depends on gbn_pkg,
// gbn_frame_ram, gbn_seq_ctrl, gbn_out_stage and the assertion macros header.
`include "go_back_n_sender_window_defines.svh"

module go_back_n_sender_window (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// tdata: payload[31:0], ack_number[34:32], zero fill
	input  logic [gbn_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// tuser: action[1:0]
	input  logic [gbn_pkg::USER_W-1:0]     s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// tdata: seq[2:0], frame_data[34:3], freed[37:35], outstanding[40:38], zero fill
	output logic [gbn_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// tuser: kind[1:0]
	output logic [gbn_pkg::USER_W-1:0]     m_axis_tuser,
	output logic                           m_axis_tlast
);
	import gbn_pkg::*;

	action_t  in_action;
	payload_t in_payload;
	seq_t     in_ack;
	result_t  res;
	logic     res_load;
	logic     out_free;
	result_t  beat;
	logic     ram_wr_en;
	seq_t     ram_wr_addr;
	payload_t ram_wr_data;
	logic     ram_rd_en;
	seq_t     ram_rd_addr;
	payload_t ram_rd_data;
	status_t  status;

	// Request unpacking
	assign in_action  = action_t'(s_axis_tuser);
	assign in_payload = s_axis_tdata[PAYLOAD_BITS-1:0];
	assign in_ack     = s_axis_tdata[PAYLOAD_BITS +: SEQ_BITS];

	gbn_seq_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_action   (in_action),
		.in_payload  (in_payload),
		.in_ack      (in_ack),
		.out_free    (out_free),
		.res         (res),
		.res_load    (res_load),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data),
		.ram_rd_en   (ram_rd_en),
		.ram_rd_addr (ram_rd_addr),
		.ram_rd_data (ram_rd_data),
		.status      (status)
	);

	gbn_frame_ram #(
		.ADDR_BITS (SEQ_BITS),
		.DATA_BITS (PAYLOAD_BITS)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	gbn_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_load),
		.din       (res),
		.free      (out_free),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.dout      (beat)
	);

	// Result packing
	assign m_axis_tdata = OUT_DATA_W'({beat.outstanding, beat.freed, beat.frame_data, beat.seq});
	assign m_axis_tuser = USER_W'(beat.kind);
	assign m_axis_tlast = beat.last;

	// Window count always matches the pointer distance
	`GBN_ASSERT(a_window_count, (seq_t'(status.next_seq - status.oldest) == status.in_flight), "count off")
	// No request taken during a retransmit walk
	`GBN_ASSERT(a_busy_blocks_input, (status.busy |-> !s_axis_tready), "taken while busy")
	// The final beat of a request returns the sequencer to idle
	`GBN_ASSERT(a_last_ends_walk, ((res_load && res.last) |=> !status.busy), "busy after last")
	// A beat is never loaded over one that is still stalled
	`GBN_ASSERT(a_no_overwrite, ((m_axis_tvalid && !m_axis_tready) |-> !res_load), "beat overwritten")

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the go-back-n sender window: directed window cases, then
// random requests, with random gaps and stalls on both stream channels.
// Depends on gbn_pkg and the go_back_n_sender_window top level only.
`timescale 1ns / 100ps

module tb_top;
	import gbn_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// tdata: payload[31:0], ack_number[34:32], zero fill
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	// tuser: action[1:0]
	logic [USER_W-1:0]     s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// tdata: seq[2:0], frame_data[34:3], freed[37:35], outstanding[40:38], zero fill
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	// tuser: kind[1:0]
	logic [USER_W-1:0]     m_axis_tuser;
	logic                  m_axis_tlast;

	// Local copy of the window and its frame store
	seq_t     win_next = '0;
	seq_t     win_oldest = '0;
	seq_t     win_count = '0;
	payload_t frame_copy [1 << SEQ_BITS];
	result_t  due_beats [$];
	int       err_count = 0;
	bit       stall_on = 1'b1;

	go_back_n_sender_window dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Receiver stalls at random while stall_on is set
	always @(posedge clk) begin
		m_axis_tready <= !(stall_on && $urandom_range(0, 99) < 13);
	end

	// Update the window copy for one accepted request and queue the beats it causes
	task automatic advance_window(input action_t act, input payload_t pay, input seq_t ackn);
		result_t beat;
		seq_t    offset;
		beat = '0;
		beat.last = 1'b1;
		case (act)
			ACT_SEND: begin
				beat.seq = win_next;
				if (win_count == WINDOW) begin
					beat.kind = KIND_REFUSED;
					beat.outstanding = win_count;
				end else begin
					frame_copy[win_next] = pay;
					win_count = win_count + seq_t'(1);
					beat.kind = KIND_FRAME;
					beat.frame_data = pay;
					beat.outstanding = win_count;
					win_next = win_next + seq_t'(1);
				end
				due_beats.push_back(beat);
			end
			ACT_ACK: begin
				// in window when the ack lies within the outstanding run
				offset = ackn - win_oldest;
				if (offset < win_count) begin
					beat.freed = offset + seq_t'(1);
					win_oldest = ackn + seq_t'(1);
					win_count = win_count - beat.freed;
				end
				beat.kind = KIND_ACK;
				beat.outstanding = win_count;
				due_beats.push_back(beat);
			end
			default: begin
				if (win_count == '0) begin
					beat.kind = KIND_NONE;
					due_beats.push_back(beat);
				end else begin
					// replay oldest first; next number ends where it began
					for (int k = 0; k < int'(win_count); k++) begin
						beat.kind = KIND_FRAME;
						beat.seq = win_oldest + seq_t'(k);
						beat.frame_data = frame_copy[beat.seq];
						beat.outstanding = win_count;
						beat.last = (k == int'(win_count) - 1);
						due_beats.push_back(beat);
					end
				end
			end
		endcase
	endtask

	// Offer one request beat, with an optional random gap, and wait until it is taken
	task automatic send_req(input action_t act, input payload_t pay, input seq_t ackn);
		while (stall_on && $urandom_range(0, 99) < 13) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= {{(IN_DATA_W - PAYLOAD_BITS - SEQ_BITS){1'b0}}, ackn, pay};
		do @(posedge clk); while (!s_axis_tready);
		advance_window(act, pay, ackn);
	endtask

	// Stop offering and let every queued beat come out
	task automatic drain_window();
		s_axis_tvalid <= 1'b0;
		while (due_beats.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			err_count++;
		end
	endfunction

	// Compare every result beat with the oldest expectation
	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind        = kind_t'(m_axis_tuser);
			got.seq         = m_axis_tdata[SEQ_BITS-1:0];
			got.frame_data  = m_axis_tdata[SEQ_BITS +: PAYLOAD_BITS];
			got.freed       = m_axis_tdata[SEQ_BITS + PAYLOAD_BITS +: SEQ_BITS];
			got.outstanding = m_axis_tdata[2 * SEQ_BITS + PAYLOAD_BITS +: SEQ_BITS];
			got.last        = m_axis_tlast;
			if (due_beats.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual %0h", $time, got);
				err_count++;
			end else begin
				want = due_beats.pop_front();
				check_field("kind", 32'(want.kind), 32'(got.kind));
				check_field("seq", 32'(want.seq), 32'(got.seq));
				check_field("frame_data", want.frame_data, got.frame_data);
				check_field("freed", 32'(want.freed), 32'(got.freed));
				check_field("outstanding", 32'(want.outstanding), 32'(got.outstanding));
				check_field("last", 32'(want.last), 32'(got.last));
			end
		end
	end

	// Nak, timeout and acks while nothing is outstanding
	task automatic test_empty_window();
		send_req(ACT_NAK, $urandom(), '0);
		send_req(ACT_TIMEOUT, $urandom(), '1);
		send_req(ACT_ACK, $urandom(), '0);
		send_req(ACT_ACK, $urandom(), '1);
	endtask

	// Fill all seven slots with no idling, then one send past a full window
	task automatic test_fill_window();
		stall_on = 1'b0;
		send_req(ACT_SEND, 32'h0000_0000, '0);
		send_req(ACT_SEND, 32'hFFFF_FFFF, '1);
		send_req(ACT_SEND, 32'hA5A5_5A5A, '0);
		send_req(ACT_SEND, 32'h5A5A_A5A5, '1);
		send_req(ACT_SEND, 32'h8000_0001, '0);
		send_req(ACT_SEND, 32'h7FFF_FFFE, '1);
		send_req(ACT_SEND, $urandom(), '0);
		send_req(ACT_SEND, $urandom(), '0);
		stall_on = 1'b1;
	endtask

	// Full-window replay on nak and on timeout
	task automatic test_retransmit();
		send_req(ACT_NAK, $urandom(), '0);
		send_req(ACT_TIMEOUT, $urandom(), '0);
	endtask

	// Acks outside and inside the window, then a replay across the sequence wrap
	task automatic test_ack_wrap();
		send_req(ACT_ACK, $urandom(), seq_t'(7));
		send_req(ACT_ACK, $urandom(), seq_t'(2));
		send_req(ACT_ACK, $urandom(), seq_t'(6));
		send_req(ACT_SEND, $urandom(), '0);
		send_req(ACT_SEND, $urandom(), '0);
		send_req(ACT_SEND, $urandom(), '0);
		send_req(ACT_TIMEOUT, $urandom(), '0);
		send_req(ACT_ACK, $urandom(), seq_t'(0));
		send_req(ACT_ACK, $urandom(), seq_t'(1));
	endtask

	// Mixed traffic; most acks land inside the outstanding run
	task automatic test_random_traffic();
		int       pick;
		action_t  act;
		seq_t     ackn;
		for (int n = 0; n < 100; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				act = ACT_SEND;
			else if (pick < 70)
				act = ACT_ACK;
			else if (pick < 85)
				act = ACT_NAK;
			else
				act = ACT_TIMEOUT;
			if (act == ACT_ACK && win_count != '0 && $urandom_range(0, 3) != 0)
				ackn = win_oldest + seq_t'($urandom_range(0, int'(win_count) - 1));
			else
				ackn = seq_t'($urandom_range(0, (1 << SEQ_BITS) - 1));
			send_req(act, $urandom(), ackn);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_window();
		test_fill_window();
		test_retransmit();
		test_ack_wrap();
		test_random_traffic();
		drain_window();
		if (err_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	// Run limit
	initial begin
		#200000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/gbn_pkg.sv
hdl/gbn_frame_ram.sv
hdl/gbn_seq_ctrl.sv
hdl/gbn_out_stage.sv
hdl/go_back_n_sender_window.sv
tb/sv/tb_top.sv
